/* hw/rtl/double_hash_table_macros.svh */
// Assertion macros shared by the hash table RTL.
// Depends on nothing; included by the top level only.
`ifndef DOUBLE_HASH_TABLE_MACROS_SVH
`define DOUBLE_HASH_TABLE_MACROS_SVH

// Same-cycle implication, checked out of reset
`define DHT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hash table check failed");

// Next-cycle implication, checked out of reset
`define DHT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hash table check failed");

`endif

/* hw/rtl/dht_pkg.sv */
// Shared types and constants of the double hashing table.
// Used by the controller, the datapath and the top level.
package dht_pkg;

  localparam int DHT_SLOTS    = 13;
  localparam int DHT_STEP_MOD = 11;
  localparam int DHT_KEY_W    = 16;
  localparam int DHT_KEY_BITS = 16;
  localparam int DHT_SLOT_W   = 4;
  localparam int DHT_OP_W     = 2;
  localparam int DHT_STS_W    = 3;

  typedef enum logic [DHT_OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_DELETE = 2'd2
  } dht_op_e;

  typedef enum logic [DHT_STS_W-1:0] {
    STS_INSERTED  = 3'd0,
    STS_FULL      = 3'd1,
    STS_FOUND     = 3'd2,
    STS_NOT_FOUND = 3'd3,
    STS_DELETED   = 3'd4,
    STS_DEL_MISS  = 3'd5
  } dht_status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_QUOT,
    ST_REM,
    ST_READ,
    ST_PROBE,
    ST_EMIT
  } dht_state_e;

  typedef struct packed {
    logic [DHT_OP_W-1:0]  operation;
    logic [DHT_KEY_W-1:0] key;
  } dht_in_t;

  typedef struct packed {
    logic [DHT_STS_W-1:0]  status;
    logic [DHT_SLOT_W-1:0] slot;
  } dht_out_t;

  typedef struct packed {
    logic load_in;
    logic calc_quot;
    logic calc_rem;
    logic probe;
    logic load_out;
  } dht_cmd_t;

  typedef struct packed {
    logic op_bad;
    logic done;
  } dht_sts_t;

endpackage

/* hw/rtl/dht_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module dht_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 13
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/dht_ctrl.sv */
// Sequencer of the hash table: accept, hash setup, probe walk, result beat.
// Depends on dht_pkg.
module dht_ctrl import dht_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  input  dht_sts_t sts_i,
  output dht_cmd_t cmd_o
);

  dht_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_QUOT;
        end
      end
      ST_QUOT: begin
        cmd_o.calc_quot = 1'b1;
        state_d         = ST_REM;
      end
      ST_REM: begin
        cmd_o.calc_rem = 1'b1;
        state_d        = sts_i.op_bad ? ST_EMIT : ST_READ;
      end
      ST_READ: begin
        state_d = ST_PROBE;
      end
      ST_PROBE: begin
        cmd_o.probe = 1'b1;
        if (sts_i.done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold the result beat until taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

/* hw/rtl/dht_datapath.sv */
// Datapath of the hash table: key hashing, probe position walk, key store,
// occupancy bits and result register. Depends on dht_pkg and dht_ram.
module dht_datapath import dht_pkg::*; #(
  parameter int KEY_BITS = DHT_KEY_BITS
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  dht_in_t  in_data_i,
  input  dht_cmd_t cmd_i,
  output dht_sts_t sts_o,
  output dht_out_t out_data_o
);

  localparam int KW   = (KEY_BITS < DHT_KEY_W) ? KEY_BITS : DHT_KEY_W;
  localparam int QW   = KW - 3;
  localparam int QS13 = KW + $clog2(DHT_SLOTS);
  localparam int QS11 = KW + $clog2(DHT_STEP_MOD);
  localparam int PW   = 2 * KW + 1;
  localparam int SW   = DHT_SLOT_W;
  localparam logic [KW:0] M13 = (KW+1)'(((1 << QS13) + DHT_SLOTS - 1) / DHT_SLOTS);
  localparam logic [KW:0] M11 = (KW+1)'(((1 << QS11) + DHT_STEP_MOD - 1) / DHT_STEP_MOD);

  logic [DHT_OP_W-1:0] op_q;
  logic [KW-1:0]       key_q;
  logic [QW-1:0]       quot13_q, quot11_q;
  logic [SW-1:0]       pos_q, step_q, attempt_q;
  logic [DHT_SLOTS-1:0] used_q;
  dht_out_t            res_q, res_d, out_q;

  logic [PW-1:0]       prod13, prod11;
  logic [KW-1:0]       back13, back11, rem13, rem11;
  logic [SW:0]         pos_sum;
  logic [SW-1:0]       pos_adv, raddr;
  logic [KW-1:0]       rd_key;
  logic                slot_used, key_match, hit, op_bad, ram_we;

  // Quotients by reciprocal multiplication (exact for KW-bit keys)
  assign prod13 = {{(KW+1){1'b0}}, key_q} * {{KW{1'b0}}, M13};
  assign prod11 = {{(KW+1){1'b0}}, key_q} * {{KW{1'b0}}, M11};

  // Remainders from the registered quotients
  assign back13 = {3'b000, quot13_q} * KW'(DHT_SLOTS);
  assign back11 = {3'b000, quot11_q} * KW'(DHT_STEP_MOD);
  assign rem13  = key_q - back13;
  assign rem11  = key_q - back11;

  // Advance the probe position modulo the table size
  assign pos_sum = {1'b0, pos_q} + {1'b0, step_q};
  assign pos_adv = (pos_sum >= (SW+1)'(DHT_SLOTS)) ?
                   SW'(pos_sum - (SW+1)'(DHT_SLOTS)) : pos_sum[SW-1:0];

  // Read the next position while the current one is checked
  assign raddr = cmd_i.probe ? pos_adv : pos_q;

  assign op_bad = !(op_q == OP_INSERT || op_q == OP_SEARCH || op_q == OP_DELETE);

  // Probe decision
  always_comb begin
    slot_used = used_q[pos_q];
    key_match = slot_used && (rd_key == key_q);
    hit       = 1'b1;
    res_d     = '0;
    case (op_q)
      OP_INSERT: begin
        hit          = !slot_used;
        res_d.status = hit ? STS_INSERTED : STS_FULL;
        res_d.slot   = hit ? pos_q : '0;
      end
      OP_SEARCH: begin
        hit          = !slot_used || key_match;
        res_d.status = key_match ? STS_FOUND : STS_NOT_FOUND;
        res_d.slot   = key_match ? pos_q : '0;
      end
      OP_DELETE: begin
        hit          = key_match;
        res_d.status = key_match ? STS_DELETED : STS_DEL_MISS;
        res_d.slot   = key_match ? pos_q : '0;
      end
      default: begin
        hit          = 1'b1;
        res_d.status = STS_NOT_FOUND;
        res_d.slot   = '0;
      end
    endcase
  end

  assign sts_o.done   = hit || (attempt_q == SW'(DHT_SLOTS - 1));
  assign sts_o.op_bad = op_bad;
  assign ram_we       = cmd_i.probe && (op_q == OP_INSERT) && !slot_used;

  // Item, hash, walk and result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      op_q  <= in_data_i.operation;
      key_q <= in_data_i.key[KW-1:0];
    end
    if (cmd_i.calc_quot) begin
      quot13_q <= prod13[PW-1:QS13];
      quot11_q <= prod11[PW-1:QS11];
    end
    if (cmd_i.calc_rem) begin
      pos_q     <= rem13[SW-1:0];
      step_q    <= rem11[SW-1:0] + SW'(1);
      attempt_q <= '0;
      if (op_bad) begin
        res_q.status <= STS_NOT_FOUND;
        res_q.slot   <= '0;
      end
    end
    if (cmd_i.probe) begin
      if (sts_o.done) begin
        res_q <= res_d;
      end else begin
        pos_q     <= pos_adv;
        attempt_q <= attempt_q + SW'(1);
      end
    end
    if (cmd_i.load_out) begin
      out_q <= res_q;
    end
  end

  // Occupancy bits: set on insert, clear on delete
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else if (cmd_i.probe) begin
      if (ram_we) begin
        used_q[pos_q] <= 1'b1;
      end else if ((op_q == OP_DELETE) && key_match) begin
        used_q[pos_q] <= 1'b0;
      end
    end
  end

  dht_ram #(
    .WIDTH (KW),
    .DEPTH (DHT_SLOTS)
  ) u_keys (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (pos_q),
    .wdata_i (key_q),
    .raddr_i (raddr),
    .rdata_o (rd_key)
  );

  assign out_data_o = out_q;

endmodule

/* hw/rtl/double_hash_table.sv */
// A 13-slot open-addressing hash table with double hashing; each input beat
// (insert, search or delete of a key) gives one result beat. An item passes
// through the sequencer states in order: QUOT and REM work out key mod 13 and
// key mod 11, READ reads the first slot from the key RAM, PROBE walks n probes
// (1 to 13) on the single read port, and EMIT loads the result register,
// waiting while an earlier result beat is still stalled. The next beat can
// be accepted in the cycle the result turns valid. An unused operation code
// goes from REM straight to EMIT, skipping the key RAM read and probe walk.
// Depends on dht_pkg, dht_ctrl, dht_datapath and the macros header.
`include "double_hash_table_macros.svh"

module double_hash_table import dht_pkg::*; #(
  parameter int KEY_BITS = DHT_KEY_BITS
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  dht_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output dht_out_t out_data_o
);

  dht_cmd_t cmd;
  dht_sts_t sts;

  dht_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  dht_datapath #(
    .KEY_BITS (KEY_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

  // Busy right after an accepted beat
  `DHT_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
  // Never overwrite a result beat that is still stalled
  `DHT_ASSERT_IMP(a_no_overwrite, clk_i, rst_ni, cmd.load_out, !out_valid_o || !out_stall_i)
  // A loaded result shows up as valid
  `DHT_ASSERT_NXT(a_load_shows, clk_i, rst_ni, cmd.load_out, out_valid_o)
  // At most one sequencer command at a time
  `DHT_ASSERT_IMP(a_cmd_onehot, clk_i, rst_ni, 1'b1, $onehot0(cmd))

endmodule
